// ===== src/heater_band_pi_controller_top_assert.svh =====
// Assertion macros shared by the heater band PI controller RTL.
// Every macro samples on the rising edge of clk and is disabled while rst is high.
`ifndef HEATER_BAND_PI_CONTROLLER_TOP_ASSERT_SVH
`define HEATER_BAND_PI_CONTROLLER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HBPI_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HBPI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/hbpi_pkg.sv =====
// ----------------------------------------------------------------------------
// hbpi_pkg
// Types and constants shared by the heater band PI controller modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hbpi_pkg;

  localparam int TEMP_W     = 16;
  localparam int BAND_W     = 12;
  localparam int GAIN_W     = 24;
  localparam int DRIVE_W    = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int FRAC_W     = 16;
  localparam int ERR_W      = TEMP_W + 1;
  localparam int PROD_W     = GAIN_W + 1 + ERR_W;
  localparam int FF_W       = GAIN_W + 1 + TEMP_W;
  localparam int INTEG_W    = 48;
  localparam int SUM_W      = INTEG_W + 2;
  localparam int WHOLE_W    = SUM_W - FRAC_W;

  localparam logic signed [TEMP_W-1:0] TARGET_TEMP_RST = '0;
  localparam logic [BAND_W-1:0]        BAND_WIDTH_RST  = BAND_W'(128);
  localparam logic [GAIN_W-1:0]        PROP_GAIN_RST   = GAIN_W'(1073742);
  localparam logic [GAIN_W-1:0]        INTEG_GAIN_RST  = GAIN_W'(10737);
  localparam logic [GAIN_W-1:0]        FF_GAIN_RST     = GAIN_W'(335544);
  localparam logic [DRIVE_W-1:0]       OUTPUT_MAX_RST  = DRIVE_W'(32768);

  localparam logic signed [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
  localparam logic signed [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET_TEMP = 3'd0,
    CFG_BAND_WIDTH  = 3'd1,
    CFG_PROP_GAIN   = 3'd2,
    CFG_INTEG_GAIN  = 3'd3,
    CFG_FF_GAIN     = 3'd4,
    CFG_OUTPUT_MAX  = 3'd5
  } hbpi_cfg_idx_t;

  typedef enum logic [1:0] {
    CLS_OFF   = 2'd0,
    CLS_BELOW = 2'd1,
    CLS_ABOVE = 2'd2,
    CLS_BAND  = 2'd3
  } hbpi_class_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temperature;
    logic                     enable;
  } hbpi_in_t;

  typedef struct packed {
    logic [DRIVE_W-1:0] drive;
    logic               settled;
  } hbpi_out_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] target_temp;
    logic [BAND_W-1:0]        band_width;
    logic [GAIN_W-1:0]        prop_gain;
    logic [GAIN_W-1:0]        integ_gain;
    logic [DRIVE_W-1:0]       output_max;
    logic signed [FF_W-1:0]   ff_term;
  } hbpi_cfg_t;

  typedef struct packed {
    hbpi_class_t              cls;
    logic signed [PROD_W-1:0] prop_term;
    logic signed [PROD_W-1:0] integ_inc;
  } hbpi_prod_t;

endpackage

`default_nettype wire

// ===== src/heater_band_pi_controller_top.sv =====
// ----------------------------------------------------------------------------
// heater_band_pi_controller_top
// Heater drive controller: bang-bang outside a band around the setpoint,
// feedforward plus PI law with a saturating integral inside it.
// ----------------------------------------------------------------------------
// Usage:
// Each input transaction on in_valid/in_ready carries one temperature sample
// (signed, 1/16 degree) and an enable bit. Each one produces exactly one
// output transaction on out_valid/out_ready carrying the drive level and the
// settled flag, in the same order.
// The datapath is three registers deep: input register, product register
// (error, band class, two 24x17 products) and result register (integral
// update, sum and clamp). A result is offered once its input has passed the
// product and result registers; one transaction per cycle is sustained while
// out_ready is high; the integral update in the last stage sets that rate.
// When the receiver stalls, the stages fill up one by one and in_ready falls
// only once all three hold an item, so up to three results wait inside.
// Configuration registers are written through cfg_we/cfg_index/cfg_data at
// any edge with cfg_we high and should change only while no transaction is
// in flight. Unknown indexes are ignored.
// Synchronous reset restores the register defaults, clears the integral and
// empties the pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module heater_band_pi_controller_top (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output      logic                           in_ready,
  input  hbpi_pkg::hbpi_in_t                  in_data,
  output      logic                           out_valid,
  input  wire logic                           out_ready,
  output hbpi_pkg::hbpi_out_t                 out_data,
  input  wire logic                           cfg_we,
  input  wire logic [hbpi_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [hbpi_pkg::CFG_DATA_W-1:0] cfg_data
);
  import hbpi_pkg::*;

  `include "heater_band_pi_controller_top_assert.svh"

  hbpi_cfg_t  cfg;
  hbpi_in_t   s1_item;
  hbpi_prod_t prod;
  logic       s1_valid;
  logic       s2_valid;
  logic       s1_load;
  logic       s2_load;
  logic       out_load;
  logic       drive_at_rail;

  hbpi_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Each stage moves forward when the stage after it is empty or is itself
  // moving forward this cycle, so bubbles close up even while out_ready is low.
  assign out_load = s2_valid && (!out_valid || out_ready);
  assign s2_load  = s1_valid && (!s2_valid || out_load);
  assign in_ready = !s1_valid || s2_load;
  assign s1_load  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid <= 1'b1;
      end else if (s2_load) begin
        s1_valid <= 1'b0;
      end
      if (s2_load) begin
        s2_valid <= 1'b1;
      end else if (out_load) begin
        s2_valid <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Input register: the sample is held here until the product stage takes it.
  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_item <= in_data;
    end
  end

  hbpi_mult u_mult (
    .clk  (clk),
    .load (s2_load),
    .item (s1_item),
    .cfg  (cfg),
    .prod (prod)
  );

  hbpi_accum u_accum (
    .clk    (clk),
    .rst    (rst),
    .load   (out_load),
    .prod   (prod),
    .cfg    (cfg),
    .result (out_data)
  );

  // An unsettled result is always one of the two rails.
  assign drive_at_rail = (out_data.drive == '0) || (out_data.drive == cfg.output_max);

  `HBPI_ASSERT_SAME(a_drive_limit, out_valid, out_data.drive <= cfg.output_max, "over max")
  `HBPI_ASSERT_SAME(a_unsettled_rail, out_valid && !out_data.settled, drive_at_rail, "off rail")
  `HBPI_ASSERT_SAME(a_ready_on_room, !s2_valid, in_ready, "input stalled with room")

endmodule

`default_nettype wire

// ===== src/hbpi_cfg.sv =====
// ----------------------------------------------------------------------------
// hbpi_cfg
// Configuration registers and the registered setpoint feedforward product.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hbpi_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [hbpi_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [hbpi_pkg::CFG_DATA_W-1:0] cfg_data,
  output hbpi_pkg::hbpi_cfg_t                 cfg
);
  import hbpi_pkg::*;

  logic signed [TEMP_W-1:0] target_temp;
  logic [BAND_W-1:0]        band_width;
  logic [GAIN_W-1:0]        prop_gain;
  logic [GAIN_W-1:0]        integ_gain;
  logic [GAIN_W-1:0]        ff_gain;
  logic [DRIVE_W-1:0]       output_max;
  logic signed [FF_W-1:0]   ff_term;
  logic signed [FF_W-1:0]   ff_term_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_temp <= TARGET_TEMP_RST;
      band_width  <= BAND_WIDTH_RST;
      prop_gain   <= PROP_GAIN_RST;
      integ_gain  <= INTEG_GAIN_RST;
      ff_gain     <= FF_GAIN_RST;
      output_max  <= OUTPUT_MAX_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TARGET_TEMP: target_temp <= $signed(cfg_data[TEMP_W-1:0]);
        CFG_BAND_WIDTH:  band_width  <= cfg_data[BAND_W-1:0];
        CFG_PROP_GAIN:   prop_gain   <= cfg_data[GAIN_W-1:0];
        CFG_INTEG_GAIN:  integ_gain  <= cfg_data[GAIN_W-1:0];
        CFG_FF_GAIN:     ff_gain     <= cfg_data[GAIN_W-1:0];
        CFG_OUTPUT_MAX:  output_max  <= cfg_data[DRIVE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // The feedforward depends on configuration only, so it is computed here
  // every cycle and reaches the accumulate stage long before any item does.
  assign ff_term_next = $signed({1'b0, ff_gain}) * target_temp;

  always_ff @(posedge clk) begin
    ff_term <= ff_term_next;
  end

  assign cfg.target_temp = target_temp;
  assign cfg.band_width  = band_width;
  assign cfg.prop_gain   = prop_gain;
  assign cfg.integ_gain  = integ_gain;
  assign cfg.output_max  = output_max;
  assign cfg.ff_term     = ff_term;

endmodule

`default_nettype wire

// ===== src/hbpi_mult.sv =====
// ----------------------------------------------------------------------------
// hbpi_mult
// Error, band classification and the proportional and integral products.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hbpi_mult (
  input  wire logic                 clk,
  input  wire logic                 load,
  input  hbpi_pkg::hbpi_in_t        item,
  input  hbpi_pkg::hbpi_cfg_t       cfg,
  output hbpi_pkg::hbpi_prod_t      prod
);
  import hbpi_pkg::*;

  logic signed [ERR_W-1:0] err;
  logic signed [ERR_W:0]   err_x;
  logic signed [ERR_W:0]   band_s;
  hbpi_prod_t              prod_next;

  always_comb begin
    err    = $signed({cfg.target_temp[TEMP_W-1], cfg.target_temp})
           - $signed({item.temperature[TEMP_W-1], item.temperature});
    err_x  = $signed({err[ERR_W-1], err});
    band_s = $signed({{(ERR_W+1-BAND_W){1'b0}}, cfg.band_width});

    // A positive error beyond the band means the sample is below the band.
    if (!item.enable) begin
      prod_next.cls = CLS_OFF;
    end else if (err_x > band_s) begin
      prod_next.cls = CLS_BELOW;
    end else if (err_x < -band_s) begin
      prod_next.cls = CLS_ABOVE;
    end else begin
      prod_next.cls = CLS_BAND;
    end

    prod_next.prop_term = $signed({1'b0, cfg.prop_gain}) * err;
    prod_next.integ_inc = $signed({1'b0, cfg.integ_gain}) * err;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      prod <= prod_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/hbpi_accum.sv =====
// ----------------------------------------------------------------------------
// hbpi_accum
// Saturating integral update, PI sum, clamp and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hbpi_accum (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 load,
  input  hbpi_pkg::hbpi_prod_t      prod,
  input  hbpi_pkg::hbpi_cfg_t       cfg,
  output hbpi_pkg::hbpi_out_t       result
);
  import hbpi_pkg::*;

  `include "heater_band_pi_controller_top_assert.svh"

  logic signed [INTEG_W-1:0] integral;
  logic signed [INTEG_W-1:0] integral_next;
  logic signed [INTEG_W:0]   integ_raw;
  logic signed [SUM_W-1:0]   sum;
  logic [WHOLE_W-1:0]        whole;
  hbpi_out_t                 result_next;

  always_comb begin
    integ_raw = (INTEG_W+1)'(integral) + (INTEG_W+1)'(prod.integ_inc);
    // The top two bits differ only when the add left the 48-bit range.
    if (integ_raw[INTEG_W] != integ_raw[INTEG_W-1]) begin
      integral_next = integ_raw[INTEG_W] ? INTEG_MIN : INTEG_MAX;
    end else begin
      integral_next = integ_raw[INTEG_W-1:0];
    end

    sum   = SUM_W'(cfg.ff_term) + SUM_W'(prod.prop_term) + SUM_W'(integral_next);
    whole = sum[SUM_W-1:FRAC_W];

    result_next.drive   = '0;
    result_next.settled = 1'b0;
    case (prod.cls)
      CLS_OFF:   result_next.drive = '0;
      CLS_BELOW: result_next.drive = cfg.output_max;
      CLS_ABOVE: result_next.drive = '0;
      CLS_BAND: begin
        result_next.settled = 1'b1;
        if (sum <= 0) begin
          result_next.drive = '0;
        end else if (whole > WHOLE_W'(cfg.output_max)) begin
          result_next.drive = cfg.output_max;
        end else begin
          result_next.drive = whole[DRIVE_W-1:0];
        end
      end
      default: result_next.drive = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integral <= '0;
    end else if (load && (prod.cls == CLS_BAND)) begin
      integral <= integral_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= result_next;
    end
  end

  `HBPI_ASSERT_NEXT(a_integ_hold_idle, !load, $stable(integral), "integral moved without a load")
  `HBPI_ASSERT_NEXT(a_integ_hold_out, load && (prod.cls != CLS_BAND), $stable(integral), "integral moved outside the band")
  `HBPI_ASSERT_NEXT(a_off_zero, load && (prod.cls == CLS_OFF), (result.drive == '0) && !result.settled, "disabled item gave drive")

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the heater band PI controller.
// A table of directed samples runs first at the reset settings. It is followed
// by phases of random samples, each under its own register setting: extreme
// settings, truncated wide writes, random settings, a long output stall, and an
// integral wind-up in both directions. Every result is compared field by field
// with an in-order store of predictions.
// ----------------------------------------------------------------------------
module tb;
  import hbpi_pkg::*;

  // The datapath is three registers deep; the waits at the end of a phase are
  // reckoned from this depth.
  localparam int PIPE_DEPTH = 3;
  // Length of the long output stall that fills the pipeline.
  localparam int LONG_HOLD = 60;
  // Register indexes that the block does not decode.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
  localparam logic [GAIN_W-1:0] GAIN_FULL = '1;
  localparam longint INTEG_TOP = INTEG_MAX;
  localparam longint INTEG_BOTTOM = INTEG_MIN;

  // One row of the directed table. When known is set, the row carries its own
  // expected result; otherwise the predictor supplies it.
  typedef struct packed {
    logic signed [TEMP_W-1:0] temperature;
    logic                     enable;
    logic                     known;
    logic [DRIVE_W-1:0]       drive;
    logic                     settled;
  } sample_row_t;

  // Directed samples at the reset settings: setpoint 0, band 128.
  localparam sample_row_t DIRECTED [17] = '{
    // Disabled: the drive is held at zero whatever the temperature.
    '{16'sd0,      1'b0, 1'b1, 16'd0,          1'b0},
    '{16'sh8000,   1'b0, 1'b1, 16'd0,          1'b0},
    '{16'sh7FFF,   1'b0, 1'b1, 16'd0,          1'b0},
    '{16'sh5555,   1'b0, 1'b1, 16'd0,          1'b0},
    // Far below and far above the band.
    '{16'sh8000,   1'b1, 1'b1, OUTPUT_MAX_RST, 1'b0},
    '{16'sh7FFF,   1'b1, 1'b1, 16'd0,          1'b0},
    '{16'shAAAA,   1'b1, 1'b1, OUTPUT_MAX_RST, 1'b0},
    '{16'sh5555,   1'b1, 1'b1, 16'd0,          1'b0},
    // Just outside the band on either side.
    '{-16'sd129,   1'b1, 1'b1, OUTPUT_MAX_RST, 1'b0},
    '{16'sd129,    1'b1, 1'b1, 16'd0,          1'b0},
    // Band edges are inclusive, then a few samples inside the band.
    '{-16'sd128,   1'b1, 1'b0, 16'd0,          1'b0},
    '{16'sd128,    1'b1, 1'b0, 16'd0,          1'b0},
    '{16'sd0,      1'b1, 1'b0, 16'd0,          1'b0},
    '{-16'sd1,     1'b1, 1'b0, 16'd0,          1'b0},
    '{16'sd1,      1'b1, 1'b0, 16'd0,          1'b0},
    '{16'sd64,     1'b1, 1'b0, 16'd0,          1'b0},
    '{-16'sd100,   1'b1, 1'b0, 16'd0,          1'b0}
  };

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  hbpi_in_t               in_data = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  hbpi_out_t              out_data;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // Predictor copy of the register file and of the integral accumulator.
  logic signed [TEMP_W-1:0] set_target = TARGET_TEMP_RST;
  logic [BAND_W-1:0]        set_band = BAND_WIDTH_RST;
  logic [GAIN_W-1:0]        set_kp = PROP_GAIN_RST;
  logic [GAIN_W-1:0]        set_ki = INTEG_GAIN_RST;
  logic [GAIN_W-1:0]        set_kff = FF_GAIN_RST;
  logic [DRIVE_W-1:0]       set_out_max = OUTPUT_MAX_RST;
  longint                   integ_acc = 0;

  // Predicted results, oldest first.
  hbpi_out_t drive_expected [$];

  // Idle limits for both sides, changed from phase to phase. A value of zero
  // gives a stretch with no idling at all.
  int src_idle_max = 0;
  int sink_idle_max = 0;
  // Set by the stimulus to ask the result side for one long stall.
  int sink_hold_request = 0;
  int mismatch_count = 0;
  int results_checked = 0;

  heater_band_pi_controller_top u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 4 ns period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Works out the result of one sample and advances the integral. Outside the
  // band or when disabled the accumulator keeps its value; inside it the new
  // value saturates at the signed 48-bit range before the sum is formed.
  function automatic hbpi_out_t predict_heater_drive(hbpi_in_t s);
    longint    temp;
    longint    tgt;
    longint    bw;
    longint    err;
    longint    acc_next;
    longint    total;
    longint    whole;
    hbpi_out_t r;
    temp = $signed(s.temperature);
    tgt  = set_target;
    bw   = set_band;
    r    = '0;
    if (s.enable) begin
      if (temp < tgt - bw) begin
        r.drive = set_out_max;
      end else if (temp > tgt + bw) begin
        r.drive = '0;
      end else begin
        err = tgt - temp;
        acc_next = integ_acc + longint'(set_ki) * err;
        if (acc_next > INTEG_TOP) begin
          acc_next = INTEG_TOP;
        end else if (acc_next < INTEG_BOTTOM) begin
          acc_next = INTEG_BOTTOM;
        end
        integ_acc = acc_next;
        r.settled = 1'b1;
        total = longint'(set_kff) * tgt + longint'(set_kp) * err + integ_acc;
        // A sum at or below zero leaves the drive at zero; otherwise the
        // fraction bits are dropped and the level is clamped.
        if (total > 0) begin
          whole = total >>> FRAC_W;
          r.drive = (whole > longint'(set_out_max)) ? set_out_max : DRIVE_W'(whole);
        end
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    mismatch_count++;
    $display("MISMATCH at %0t ns, result %0d: %s", $time, results_checked, msg);
  endtask

  task automatic check_result(hbpi_out_t got);
    hbpi_out_t want;
    if (drive_expected.size() == 0) begin
      report_mismatch($sformatf("unexpected transaction, drive %0d settled %0b",
                                got.drive, got.settled));
      return;
    end
    want = drive_expected.pop_front();
    if (got.drive !== want.drive) begin
      report_mismatch($sformatf("drive %0d, expected %0d", got.drive, want.drive));
    end
    if (got.settled !== want.settled) begin
      report_mismatch($sformatf("settled %0b, expected %0b", got.settled, want.settled));
    end
    results_checked++;
  endtask

  // Offers one sample after a random gap and holds it until it is taken. The
  // prediction is made at the accepting edge, so the integral advances in the
  // same order as in the block. A pinned result replaces the prediction.
  task automatic send_sample(hbpi_in_t s, bit pinned = 1'b0, hbpi_out_t pinned_result = '0);
    int        gap;
    hbpi_out_t predicted;
    gap = $urandom_range(0, src_idle_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = predict_heater_drive(s);
    drive_expected.push_back(pinned ? pinned_result : predicted);
  endtask

  // Stops offering samples and waits until every predicted result has been
  // seen, then lets the pipeline settle. Register writes only follow this.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (drive_expected.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 1) @(posedge clk);
  endtask

  // One register write. The enable drops between writes so that it never gets
  // two assignments in one time step.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_TARGET_TEMP: set_target = value[TEMP_W-1:0];
      CFG_BAND_WIDTH:  set_band = value[BAND_W-1:0];
      CFG_PROP_GAIN:   set_kp = value[GAIN_W-1:0];
      CFG_INTEG_GAIN:  set_ki = value[GAIN_W-1:0];
      CFG_FF_GAIN:     set_kff = value[GAIN_W-1:0];
      CFG_OUTPUT_MAX:  set_out_max = value[DRIVE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_settings(logic signed [TEMP_W-1:0] target, logic [BAND_W-1:0] band,
                               logic [GAIN_W-1:0] kp, logic [GAIN_W-1:0] ki,
                               logic [GAIN_W-1:0] kff, logic [DRIVE_W-1:0] out_max);
    // The setpoint goes out sign-extended, so its upper data bits vary too.
    write_reg(CFG_TARGET_TEMP, CFG_DATA_W'(target));
    write_reg(CFG_BAND_WIDTH, CFG_DATA_W'(band));
    write_reg(CFG_PROP_GAIN, kp);
    write_reg(CFG_INTEG_GAIN, ki);
    write_reg(CFG_FF_GAIN, kff);
    write_reg(CFG_OUTPUT_MAX, CFG_DATA_W'(out_max));
  endtask

  // Gains of every magnitude from zero up to 24 bits.
  function automatic logic [GAIN_W-1:0] random_gain();
    return GAIN_W'($urandom() >> $urandom_range(8, 32));
  endfunction

  function automatic int random_idle_max();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 3;
      default: return 10;
    endcase
  endfunction

  // Most samples land inside the band, where the integral does its work;
  // some sit right at the band edges and the rest are arbitrary words.
  function automatic hbpi_in_t random_sample();
    hbpi_in_t s;
    int       pick;
    int       tgt;
    int       bw;
    int       t;
    tgt  = set_target;
    bw   = set_band;
    pick = $urandom_range(0, 99);
    s.enable = ($urandom_range(0, 9) != 0);
    if (pick < 60) begin
      t = tgt - bw + int'($urandom_range(0, 2 * bw));
    end else if (pick < 75) begin
      t = ($urandom_range(0, 1) != 0) ? tgt + bw + int'($urandom_range(0, 1))
                                      : tgt - bw - int'($urandom_range(0, 1));
    end else begin
      t = int'($signed(TEMP_W'($urandom())));
    end
    if (t < -32768 || t > 32767) begin
      t = int'($signed(TEMP_W'($urandom())));
    end
    s.temperature = TEMP_W'(t);
    return s;
  endfunction

  // During wind-up almost every sample pushes the integral the same way;
  // now and then a random sample is mixed in.
  function automatic hbpi_in_t windup_sample(logic signed [TEMP_W-1:0] push_temp);
    hbpi_in_t s;
    if ($urandom_range(0, 15) == 0) begin
      s.temperature = TEMP_W'($urandom());
      s.enable      = $urandom_range(0, 1);
    end else begin
      s.temperature = push_temp;
      s.enable      = 1'b1;
    end
    return s;
  endfunction

  task automatic run_phase(int count);
    repeat (count) send_sample(random_sample());
  endtask

  // Result side: draws a stall before every transaction, or takes the long
  // stall when the stimulus asks for one, and checks what arrives.
  initial begin : result_sink
    int hold;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (sink_hold_request > 0) begin
        hold = sink_hold_request;
        sink_hold_request = 0;
      end else begin
        hold = $urandom_range(0, sink_idle_max);
      end
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      check_result(out_data);
    end
  end

  initial begin : stimulus
    hbpi_in_t s;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table at the reset settings. Rows with a result of their own
    // still pass through the predictor so that its integral stays in step.
    src_idle_max  = 3;
    sink_idle_max = 3;
    for (int i = 0; i < $size(DIRECTED); i++) begin
      s.temperature = DIRECTED[i].temperature;
      s.enable      = DIRECTED[i].enable;
      send_sample(s, DIRECTED[i].known, {DIRECTED[i].drive, DIRECTED[i].settled});
    end

    // Widest band with full proportional and integral gains.
    wait_drained();
    src_idle_max  = 0;
    sink_idle_max = 0;
    load_settings(16'sd0, 12'd4095, GAIN_FULL, GAIN_FULL, '0, 16'hFFFF);
    run_phase(80);

    // Lowest setpoint with full feedforward: the feedforward term is strongly
    // negative, so the sum often ends at or below zero.
    wait_drained();
    src_idle_max  = 10;
    sink_idle_max = 10;
    load_settings(16'sh8000, 12'd4095, '0, '0, GAIN_FULL, 16'hFFFF);
    run_phase(40);

    // Highest setpoint, a band of zero width and a clamp level of zero.
    wait_drained();
    src_idle_max  = 3;
    sink_idle_max = 0;
    load_settings(16'sh7FFF, 12'd0, GAIN_W'(24'h010000), GAIN_W'(1), GAIN_FULL, 16'd0);
    run_phase(40);

    // Writes with data wider than the register keep only the low bits, and
    // writes to undecoded indexes change nothing.
    wait_drained();
    src_idle_max  = 0;
    sink_idle_max = 10;
    write_reg(CFG_TARGET_TEMP, 24'hFF8123);
    write_reg(CFG_BAND_WIDTH, 24'hABC7FF);
    write_reg(CFG_OUTPUT_MAX, 24'h5A1234);
    write_reg(CFG_PROP_GAIN, random_gain());
    write_reg(CFG_INTEG_GAIN, random_gain());
    write_reg(CFG_FF_GAIN, random_gain());
    write_reg(CFG_SPARE_LO, CFG_DATA_W'($urandom()));
    write_reg(CFG_SPARE_HI, CFG_DATA_W'($urandom()));
    run_phase(60);

    // Random settings, each with its own idle pattern on both sides.
    for (int phase = 0; phase < 10; phase++) begin
      wait_drained();
      src_idle_max  = random_idle_max();
      sink_idle_max = random_idle_max();
      load_settings(($urandom_range(0, 1) != 0) ? TEMP_W'($urandom())
                                                : TEMP_W'(int'($urandom_range(0, 4000)) - 2000),
                    ($urandom_range(0, 3) == 0) ? BAND_W'($urandom_range(0, 4095))
                                                : BAND_W'($urandom_range(0, 300)),
                    random_gain(), random_gain(), random_gain(), DRIVE_W'($urandom()));
      run_phase(50);
      if (phase == 4) begin
        // The sender waits for every result, then the result side stalls for
        // a long stretch while samples keep coming back to back, so the
        // pipeline fills and the input is held off.
        wait_drained();
        sink_hold_request = LONG_HOLD;
        src_idle_max = 0;
        run_phase(30);
      end
    end

    // Integral wind-up: the largest in-band error at full integral gain drives
    // the accumulator far up, so the drive sits at the clamp, then twice as
    // many samples of the opposite error take it well below zero.
    wait_drained();
    src_idle_max  = 1;
    sink_idle_max = 1;
    load_settings(16'sd0, 12'd4095, '0, GAIN_FULL, '0, 16'hFFFF);
    repeat (30) send_sample(windup_sample(-16'sd4095));
    repeat (60) send_sample(windup_sample(16'sd4095));

    // Every sample has been taken; wait for the last results, then wait on to
    // catch anything that should not be there.
    wait_drained();
    repeat (2 * PIPE_DEPTH) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog: far longer than the slowest passing run.
  initial begin : watchdog
    #3_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
